>>> hw/rtl/pdac_pkg.sv
// Shared types and constants for the PCM DAC port with sample timer.
package pdac_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned PADDR_W = 3;

    localparam logic [DATA_W-1:0] TIMER_RATE_HZ  = 32'd15750;
    localparam logic [DATA_W-1:0] CLOCK_RESET_HZ = 32'd21477270;

    // Request codes of the input beat.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Port numbers.
    localparam logic PORT_SAMPLE = 1'b0;
    localparam logic PORT_STATUS = 1'b1;

    // Register index on the configuration port.
    localparam logic REG_CLOCK = 1'b0;

    localparam logic [7:0] STATUS_MASK   = 8'h1f;
    localparam logic [7:0] SAMPLE_MSB    = 8'h80;
    localparam logic [4:0] STAT_AUTO_BIT = 5'h02;
    localparam logic [4:0] STAT_ENA_BIT  = 5'h01;
    localparam logic [7:0] ENABLE_PAIR   = 8'h03;

    // Result of the remainder unit, handed to the top level.
    typedef struct packed {
        logic              done;
        logic [1:0]        quot_lo;
        logic [DATA_W-1:0] remainder;
    } div_result_t;

endpackage

>>> hw/rtl/pdac_divider.sv
// Restoring divider giving the remainder and the low two quotient bits.
module pdac_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [pdac_pkg::DATA_W-1:0]     dividend,
    input  logic [pdac_pkg::DATA_W-1:0]     divisor,
    output pdac_pkg::div_result_t           result
);

    localparam int unsigned CNT_W = $clog2(pdac_pkg::DATA_W);

    logic [pdac_pkg::DATA_W-1:0] rem_reg, rem_next;
    logic [pdac_pkg::DATA_W-1:0] dvd_reg, dvd_next;
    logic [pdac_pkg::DATA_W-1:0] divisor_reg;
    logic [1:0]                  q_reg, q_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [pdac_pkg::DATA_W:0]   trial;
    logic                        ge;

    // One quotient bit a cycle: bring down the next dividend bit and try the subtract.
    always_comb begin
        trial     = {rem_reg, dvd_reg[pdac_pkg::DATA_W-1]};
        ge        = trial >= {1'b0, divisor_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            dvd_next = dividend;
            q_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = ge ? trial[pdac_pkg::DATA_W-1:0] - divisor_reg
                          : trial[pdac_pkg::DATA_W-1:0];
            dvd_next = {dvd_reg[pdac_pkg::DATA_W-2:0], 1'b0};
            q_next   = {q_reg[0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(pdac_pkg::DATA_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        if (start) begin
            divisor_reg <= divisor;
        end
    end

    assign result.done      = done_reg;
    assign result.quot_lo   = q_reg;
    assign result.remainder = rem_reg;

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg && !start && divisor_reg != '0 |-> rem_reg < divisor_reg)
        else $error("partial remainder reached the divisor");

    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !run_reg)
        else $error("done raised while the divider still runs");

    a_no_double_done: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

endmodule

>>> hw/rtl/pcm_dac_port_with_sample_timer.sv
// Top level of the PCM DAC port pair with its 15750 Hz sample timer.
//
// Input beats (s_valid/s_ready) carry a request: a system clock tick, a port
// read or a port write. Every input beat yields exactly one result beat
// (m_valid/m_ready) with the read byte and, when a sample goes to the DAC,
// dac_valid and dac_value.
// The block takes one beat per cycle unless busy or stalled. A result appears
// in the cycle after its input beat is taken; the output register is refilled
// in the same cycle it is emptied; while a result waits, s_ready is m_ready unless busy.
// When the receiver stalls, the result holds and no further beat is taken.
// Writing system_clock_hz over the APB port starts a restoring division
// (start_reg starts it, and busy ends when the divider reports done) that
// reduces the phase and the timer step by the new frequency; s_ready stays
// low while busy_reg is set.
// A tick then needs only one add, one compare and one subtract on the phase.
// Reset clears the sample, status, counter and phase, sets the frequency to
// 21477270 Hz and empties the output register.
module pcm_dac_port_with_sample_timer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pdac_pkg::PADDR_W-1:0]     paddr,
    input  logic [pdac_pkg::DATA_W-1:0]      pwdata,
    output logic [pdac_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_req_type,
    input  logic                             s_port_select,
    input  logic [7:0]                       s_write_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_read_data,
    output logic                             m_dac_valid,
    output logic [7:0]                       m_dac_value
);

    logic [pdac_pkg::DATA_W-1:0] clock_reg;
    logic [pdac_pkg::DATA_W-1:0] phase_reg, phase_next;
    logic [pdac_pkg::DATA_W-1:0] norm_reg, norm_next;
    logic [pdac_pkg::DATA_W-1:0] step_rem_reg;
    logic [1:0]                  step_q_reg;
    logic [1:0]                  pend_reg, pend_next;
    logic [1:0]                  counter_reg, counter_next;
    logic [7:0]                  sample_reg, sample_next;
    logic [4:0]                  status_reg, status_next;
    logic                        busy_reg;
    logic                        start_reg;
    logic                        m_valid_reg;
    logic [7:0]                  read_data_reg, read_data_next;
    logic                        dac_valid_reg, dac_valid_next;
    logic [7:0]                  dac_value_reg, dac_value_next;

    logic                        cfg_write;
    logic                        accept;
    logic [pdac_pkg::DATA_W:0]   sum;
    logic                        wrap;
    pdac_pkg::div_result_t       phase_div;
    pdac_pkg::div_result_t       step_div;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == pdac_pkg::REG_CLOCK) ? clock_reg : '0;

    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // The phase is kept as the raw value and as its remainder by the clock;
    // the 15750 step is likewise split into its low two quotient bits and a remainder.
    pdac_divider u_phase_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (phase_reg),
        .divisor  (clock_reg),
        .result   (phase_div)
    );

    pdac_divider u_step_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (pdac_pkg::TIMER_RATE_HZ),
        .divisor  (clock_reg),
        .result   (step_div)
    );

    always_comb begin
        sum            = {1'b0, norm_reg} + {1'b0, step_rem_reg};
        wrap           = sum >= {1'b0, clock_reg};
        phase_next     = phase_reg;
        norm_next      = norm_reg;
        pend_next      = pend_reg;
        counter_next   = counter_reg;
        sample_next    = sample_reg;
        status_next    = status_reg;
        read_data_next = '0;
        dac_valid_next = 1'b0;
        dac_value_next = '0;
        case (s_req_type)
            pdac_pkg::REQ_TICK: begin
                if (clock_reg == '0) begin
                    phase_next = '0;
                    norm_next  = '0;
                end else begin
                    norm_next    = wrap ? sum[pdac_pkg::DATA_W-1:0] - clock_reg
                                        : sum[pdac_pkg::DATA_W-1:0];
                    phase_next   = norm_next;
                    counter_next = counter_reg + step_q_reg + pend_reg + {1'b0, wrap};
                end
                pend_next = '0;
            end
            pdac_pkg::REQ_READ: begin
                if (s_port_select == pdac_pkg::PORT_SAMPLE) begin
                    read_data_next = {6'b0, counter_reg};
                end else begin
                    read_data_next = (~sample_reg & pdac_pkg::SAMPLE_MSB) | {3'b0, status_reg};
                end
            end
            pdac_pkg::REQ_WRITE: begin
                if (s_port_select == pdac_pkg::PORT_SAMPLE) begin
                    counter_next = '0;
                    sample_next  = s_write_data;
                    if ((status_reg & pdac_pkg::STAT_AUTO_BIT) != '0) begin
                        dac_valid_next = 1'b1;
                        dac_value_next = s_write_data;
                    end
                end else begin
                    if ((s_write_data & pdac_pkg::ENABLE_PAIR) == pdac_pkg::ENABLE_PAIR
                        && (status_reg & pdac_pkg::STAT_ENA_BIT) == '0) begin
                        dac_valid_next = 1'b1;
                        dac_value_next = sample_reg;
                    end
                    status_next = 5'(s_write_data & pdac_pkg::STATUS_MASK);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg    <= pdac_pkg::CLOCK_RESET_HZ;
            phase_reg    <= '0;
            norm_reg     <= '0;
            step_rem_reg <= pdac_pkg::TIMER_RATE_HZ;
            step_q_reg   <= '0;
            pend_reg     <= '0;
            counter_reg  <= '0;
            sample_reg   <= '0;
            status_reg   <= '0;
            busy_reg     <= 1'b0;
            start_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            start_reg <= cfg_write && paddr[2] == pdac_pkg::REG_CLOCK;
            if (cfg_write && paddr[2] == pdac_pkg::REG_CLOCK) begin
                clock_reg <= pwdata;
                busy_reg  <= 1'b1;
            end else if (phase_div.done) begin
                busy_reg <= 1'b0;
                if (clock_reg != '0) begin
                    norm_reg     <= phase_div.remainder;
                    pend_reg     <= phase_div.quot_lo;
                    step_rem_reg <= step_div.remainder;
                    step_q_reg   <= step_div.quot_lo;
                end else begin
                    pend_reg <= '0;
                end
            end
            if (accept) begin
                phase_reg   <= phase_next;
                norm_reg    <= norm_next;
                pend_reg    <= pend_next;
                counter_reg <= counter_next;
                sample_reg  <= sample_next;
                status_reg  <= status_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            read_data_reg <= read_data_next;
            dac_valid_reg <= dac_valid_next;
            dac_value_reg <= dac_value_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = read_data_reg;
    assign m_dac_valid = dac_valid_reg;
    assign m_dac_value = dac_value_reg;

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready)
        else $error("input beat taken while the phase is being reduced");

    a_clock_write_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write && paddr[2] == pdac_pkg::REG_CLOCK |=> busy_reg)
        else $error("clock write did not start the reduction");

    a_phase_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && clock_reg != '0 |-> norm_reg < clock_reg && step_rem_reg < clock_reg)
        else $error("reduced phase or step not below the clock frequency");

    a_dac_value_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_dac_valid |-> m_dac_value == '0)
        else $error("DAC value present without a DAC beat");

endmodule
